FILE: sv/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the promotable priority table.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int CAPACITY      = 64;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int IDX_W         = $clog2(CAPACITY);

  // action codes
  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_PROMOTE = 3'd1;
  localparam logic [2:0] ACT_LOOKUP  = 3'd2;
  localparam logic [2:0] ACT_PEEK    = 3'd3;
  localparam logic [2:0] ACT_POP     = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_LIMIT   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] item_id;
    logic [31:0] payload_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [31:0] payload_out;
    logic [15:0] priority_out;
  } out_word_t;

  typedef struct packed {
    logic [31:0]              ident;
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic             load;    // capture input word, clear scan result
    logic             rd_en;   // read entry memory at rd_addr
    logic [IDX_W-1:0] rd_addr;
    logic             commit;  // apply update, register result word
  } ppt_cmd_t;

endpackage

FILE: sv/ppt_ctrl.sv
// ----------------------------------------------------------------------------
// ppt_ctrl
// Sequencer: accepts a word, sweeps every table slot once, then commits.
// ----------------------------------------------------------------------------
module ppt_ctrl import ppt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ppt_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT} state_t;

  state_t           state_r;
  logic [IDX_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (start) state_r <= S_SCAN;
        end
        S_SCAN: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(CAPACITY - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN:  state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd.load    = (state_r == S_IDLE) && start;
    cmd.rd_en   = (state_r == S_SCAN);
    cmd.rd_addr = cnt_r;
    cmd.commit  = (state_r == S_COMMIT);
  end

endmodule

FILE: sv/ppt_dpath.sv
// ----------------------------------------------------------------------------
// ppt_dpath
// Entry memory, valid bits, id counter, scan compare and result register.
// ----------------------------------------------------------------------------
module ppt_dpath import ppt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ppt_cmd_t  cmd,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = '1;

  entry_t           mem [CAPACITY];
  entry_t           mem_q_r;
  logic [IDX_W-1:0] idx_q_r;
  logic             q_vld_r;

  logic [CAPACITY-1:0] valid_r;
  logic [31:0]         next_id_r;
  in_word_t            in_r;

  // scan result
  logic             found_r;
  logic [IDX_W-1:0] slot_r;
  entry_t           best_r;

  logic             q_live;
  logic             take;

  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  out_word_t        res;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_en) mem_q_r <= mem[cmd.rd_addr];
    idx_q_r <= cmd.rd_addr;
  end

  assign q_live = valid_r[idx_q_r];

  always_comb begin
    take = 1'b0;
    if (q_vld_r) begin
      case (in_r.action)
        ACT_ADD: take = !q_live && !found_r;
        ACT_PROMOTE,
        ACT_LOOKUP: take = q_live && !found_r && (mem_q_r.ident == in_r.item_id);
        ACT_PEEK,
        ACT_POP: take = q_live && (!found_r ||
                        (mem_q_r.prio > best_r.prio) ||
                        ((mem_q_r.prio == best_r.prio) && (mem_q_r.ident > best_r.ident)));
        default: take = 1'b0;
      endcase
    end
  end

  // commit: update and result word
  always_comb begin
    we  = 1'b0;
    wa  = slot_r;
    wd  = best_r;
    res = '0;
    case (in_r.action)
      ACT_ADD: begin
        if (!found_r) begin
          res.status = ST_FULL;
        end else begin
          we            = 1'b1;
          wd.ident      = next_id_r;
          wd.prio       = '0;
          wd.payload    = PAYLOAD_BITS'(in_r.payload_in);
          res.result_id = next_id_r;
        end
      end
      ACT_PROMOTE: begin
        res.result_id = in_r.item_id;
        if (!found_r) begin
          res.status = ST_UNKNOWN;
        end else if (best_r.prio == PRIO_MAX) begin
          res.status       = ST_LIMIT;
          res.priority_out = 16'(best_r.prio);
        end else begin
          we               = 1'b1;
          wd.prio          = best_r.prio + PRIORITY_BITS'(1);
          res.priority_out = 16'(wd.prio);
        end
      end
      ACT_LOOKUP: begin
        res.result_id = in_r.item_id;
        if (!found_r) begin
          res.status = ST_UNKNOWN;
        end else begin
          res.payload_out  = 32'(best_r.payload);
          res.priority_out = 16'(best_r.prio);
        end
      end
      ACT_PEEK,
      ACT_POP: begin
        if (!found_r) begin
          res.status = ST_EMPTY;
        end else begin
          res.result_id    = best_r.ident;
          res.payload_out  = 32'(best_r.payload);
          res.priority_out = 16'(best_r.prio);
        end
      end
      default: res = '0;
    endcase
    we = we && cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_word;
    if (take) begin
      slot_r <= idx_q_r;
      best_r <= mem_q_r;
    end
    if (cmd.commit) out_word <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      next_id_r  <= '0;
      found_r    <= 1'b0;
      q_vld_r    <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      q_vld_r    <= cmd.rd_en;
      out_strobe <= cmd.commit;
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (cmd.commit && found_r) begin
        if (in_r.action == ACT_ADD) begin
          valid_r[slot_r] <= 1'b1;
          next_id_r       <= next_id_r + 32'd1;
        end else if (in_r.action == ACT_POP) begin
          valid_r[slot_r] <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: sv/promotable_priority_table_top.sv
// ----------------------------------------------------------------------------
// promotable_priority_table_top
// Priority table with add, promote, lookup, peek and pop of the max entry.
//
//   channel  ports                    handshake
//   input    in_word                  start && !busy
//   result   out_word, out_strobe     out_strobe, one cycle, no backpressure
//
// Every word passes through these steps from accept to the next accept: a
// scan that sweeps all slots through the single read port of the entry
// memory, a drain of the read register, a commit, and a return to idle,
// where busy is low. The result strobe comes in the cycle busy drops, so a
// new word may be started alongside it.
// Valid bits sit in flops and clear at reset: no clearing pass is needed.
// ----------------------------------------------------------------------------
module promotable_priority_table_top import ppt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  ppt_cmd_t cmd;

  ppt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  ppt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
